// ----- src/dtw_pkg.sv -----
// shared types, constants and the long-year table for the day count to iso week date core
package dtw_pkg;

  // calendar constants
  localparam logic [11:0] BASE_YEAR   = 12'd2000;
  localparam logic [15:0] MAR1_2100   = 16'd36584;  // day count of 1 march 2100
  localparam logic [16:0] CHUNK_DAYS  = 17'd1461;   // days in a four-year chunk
  localparam logic [26:0] CHUNK_RECIP = 27'd717;    // floor(2^20 / 1461)
  localparam int          CHUNK_SHIFT = 20;
  localparam logic [10:0] YEAR1_START = 11'd366;
  localparam logic [10:0] YEAR2_START = 11'd731;
  localparam logic [10:0] YEAR3_START = 11'd1096;
  localparam logic [5:0]  Q_2100      = 6'd25;      // chunk that starts at 2100
  localparam logic [20:0] WEEK_RECIP  = 21'd1171;   // ceil(2^13 / 7)
  localparam int          WEEK_SHIFT  = 13;
  localparam logic [5:0]  WEEKS_LONG  = 6'd53;
  localparam logic [5:0]  WEEKS_SHORT = 6'd52;

  // bit i set when year 1999 + i has 53 iso weeks
  function automatic logic [255:0] long_years_f();
    logic [255:0] tbl;
    int           prev;
    int           cur;
    int           y;
    tbl  = '0;
    prev = 4;  // weekday code of 31 december 1998
    for (int i = 0; i < 256; i++) begin
      y   = 1999 + i;
      cur = prev + 1;
      if (((y & 3) == 0) && (y != 2100) && (y != 2200)) begin
        cur = cur + 1;
      end
      if (cur >= 7) begin
        cur = cur - 7;
      end
      tbl[i] = (cur == 4) || (prev == 3);
      prev   = cur;
    end
    return tbl;
  endfunction

  localparam logic [255:0] LONG_YEARS = long_years_f();

  // day count split into four-year chunks
  typedef struct packed {
    logic        valid;
    logic [5:0]  q;      // chunk index
    logic [10:0] r;      // day within chunk
    logic        late;   // on or after 1 march 2100
    logic [2:0]  wday;
  } split_t;

  typedef struct packed {
    logic        valid;
    logic [11:0] year;
    logic [5:0]  week;
    logic [2:0]  wday;
  } result_t;

endpackage

// ----- src/dtw_split.sv -----
// weekday and four-year chunk split of the day count, three register stages
module dtw_split (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           req_valid,
  input  logic [15:0]    days,
  output dtw_pkg::split_t split
);
  import dtw_pkg::*;

  // stage a: leap fix for 2100 and weekday
  logic        late_c;
  logic [16:0] dadj_c;
  logic [16:0] s_c;
  logic [5:0]  t_c;
  logic [3:0]  u_c;
  logic [2:0]  m_c;

  always_comb begin
    late_c = (days >= MAR1_2100);
    // insert the missing 29 february 2100 so every chunk starts with a leap year
    dadj_c = {1'b0, days} + 17'(late_c);
    s_c    = {1'b0, days} + 17'd5;
    // 8 is 1 mod 7, so sum octal digits
    t_c = 6'(s_c[16:15]);
    for (int i = 0; i < 5; i++) begin
      t_c = t_c + 6'(s_c[3*i +: 3]);
    end
    u_c = 4'(t_c[5:3]) + 4'(t_c[2:0]);
    m_c = (u_c >= 4'd7) ? 3'(u_c - 4'd7) : 3'(u_c);
  end

  logic        a_valid;
  logic [16:0] a_days;
  logic        a_late;
  logic [2:0]  a_wday;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= req_valid;
    end
    if (en) begin
      a_days <= dadj_c;
      a_late <= late_c;
      a_wday <= m_c + 3'd1;
    end
  end

  // stage b: reciprocal estimate of the chunk index
  logic [26:0] prod_c;
  assign prod_c = 27'(a_days) * CHUNK_RECIP;

  logic        b_valid;
  logic [16:0] b_days;
  logic [5:0]  b_q;
  logic        b_late;
  logic [2:0]  b_wday;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_days <= a_days;
      b_q    <= prod_c[CHUNK_SHIFT +: 6];
      b_late <= a_late;
      b_wday <= a_wday;
    end
  end

  // stage c: remainder, estimate is low by at most one
  logic [16:0] base_c;
  logic [16:0] diff_c;
  logic        corr_c;

  always_comb begin
    base_c = 17'(b_q) * CHUNK_DAYS;
    diff_c = b_days - base_c;
    corr_c = (diff_c >= CHUNK_DAYS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      split.valid <= 1'b0;
    end else if (en) begin
      split.valid <= b_valid;
    end
    if (en) begin
      split.q    <= corr_c ? (b_q + 6'd1) : b_q;
      split.r    <= corr_c ? 11'(diff_c - CHUNK_DAYS) : 11'(diff_c);
      split.late <= b_late;
      split.wday <= b_wday;
    end
  end

endmodule

// ----- src/dtw_week.sv -----
// year, day of year and iso week from the chunk split, three register stages
module dtw_week (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  dtw_pkg::split_t  split,
  output dtw_pkg::result_t res
);
  import dtw_pkg::*;

  // stage d: year within chunk and day of year
  logic [1:0]  yr_c;
  logic [10:0] start_c;
  logic [8:0]  doy0_c;
  logic        fix_c;

  always_comb begin
    priority if (split.r < YEAR1_START) begin
      yr_c    = 2'd0;
      start_c = '0;
    end else if (split.r < YEAR2_START) begin
      yr_c    = 2'd1;
      start_c = YEAR1_START;
    end else if (split.r < YEAR3_START) begin
      yr_c    = 2'd2;
      start_c = YEAR2_START;
    end else begin
      yr_c    = 2'd3;
      start_c = YEAR3_START;
    end
    doy0_c = 9'(split.r - start_c);
    // 2100 is common: undo the inserted day past february
    fix_c  = split.late && (split.q == Q_2100) && (yr_c == 2'd0);
  end

  logic       d_valid;
  logic [7:0] d_off;
  logic [8:0] d_doy;
  logic [2:0] d_wday;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= split.valid;
    end
    if (en) begin
      d_off  <= {split.q, 2'b00} + 8'(yr_c);
      d_doy  <= doy0_c + 9'd1 - 9'(fix_c);
      d_wday <= split.wday;
    end
  end

  // stage e: raw week number, (doy + 10 - wday) / 7
  logic [9:0]  x_c;
  logic [20:0] wprod_c;

  always_comb begin
    x_c     = 10'(d_doy) + 10'd10 - 10'(d_wday);
    wprod_c = 21'(x_c) * WEEK_RECIP;
  end

  logic       e_valid;
  logic [7:0] e_off;
  logic [5:0] e_wk;
  logic [2:0] e_wday;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
    if (en) begin
      e_off  <= d_off;
      e_wk   <= wprod_c[WEEK_SHIFT +: 6];
      e_wday <= d_wday;
    end
  end

  // stage f: move to previous or next iso year where needed
  logic [7:0]  cur_idx_c;
  logic [5:0]  prev_weeks_c;
  logic [5:0]  cur_weeks_c;
  logic [11:0] year_c;
  logic [5:0]  week_c;

  always_comb begin
    cur_idx_c    = e_off + 8'd1;
    prev_weeks_c = LONG_YEARS[e_off] ? WEEKS_LONG : WEEKS_SHORT;
    cur_weeks_c  = LONG_YEARS[cur_idx_c] ? WEEKS_LONG : WEEKS_SHORT;
    priority if (e_wk == 6'd0) begin
      year_c = BASE_YEAR + 12'(e_off) - 12'd1;
      week_c = prev_weeks_c;
    end else if (e_wk > cur_weeks_c) begin
      year_c = BASE_YEAR + 12'(e_off) + 12'd1;
      week_c = 6'd1;
    end else begin
      year_c = BASE_YEAR + 12'(e_off);
      week_c = e_wk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= e_valid;
    end
    if (en) begin
      res.year <= year_c;
      res.week <= week_c;
      res.wday <= e_wday;
    end
  end

endmodule

// ----- src/day_count_to_iso_week_date_core.sv -----
// top level of the day count to iso week date core
// Converts a count of days since 1 January 2000 (a Saturday) into the ISO 8601
// week date: week-numbering year, week 1 to 53 and weekday 1 (Monday) to 7.
// The Gregorian calendar is followed with 2100 as a common year; every 16-bit
// day count is accepted. The core is a six-stage pipeline: a transaction can be
// accepted every cycle unless the pipeline holds. Throughput is one transaction
// per cycle, set by the single shared pipeline enable; when the result side
// stalls with a result waiting, the whole pipeline holds and req_stall rises.
// The stages are weekday and 2100 fix, chunk index multiply, chunk remainder,
// year and day of year, week multiply, and year rollover.
module day_count_to_iso_week_date_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [15:0] days_since_2000,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [11:0] iso_year,
  output logic [5:0]  iso_week,
  output logic [2:0]  iso_weekday
);
  import dtw_pkg::*;

  logic    en;
  split_t  split;
  result_t res;

  // pipeline advances unless a finished result is held by the consumer
  assign en        = !(res.valid && rsp_stall);
  assign req_stall = !en;

  dtw_split u_split (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .days      (days_since_2000),
    .split     (split)
  );

  dtw_week u_week (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .split (split),
    .res   (res)
  );

  assign rsp_valid   = res.valid;
  assign iso_year    = res.year;
  assign iso_week    = res.week;
  assign iso_weekday = res.wday;

endmodule

// ----- bench/tb_day_count_to_iso_week_date_core.sv -----
// testbench for the day count to iso week date core: directed and random day counts
`timescale 1ns / 100ps

module tb_day_count_to_iso_week_date_core;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 800;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [11:0] year;
    logic [5:0]  week;
    logic [2:0]  wday;
  } week_date_t;

  typedef struct packed {
    logic [15:0] day;
    logic        known;  // expected date typed in below
    logic [11:0] year;
    logic [5:0]  week;
    logic [2:0]  wday;
  } day_row_t;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [15:0] days_since_2000;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [11:0] iso_year;
  logic [5:0]  iso_week;
  logic [2:0]  iso_weekday;

  week_date_t expected_dates[$];
  day_row_t   directed_days[DIRECTED_ROWS];
  int         mismatches = 0;
  int         cycles = 0;
  bit         gaps_on;

  day_count_to_iso_week_date_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .days_since_2000 (days_since_2000),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .iso_year        (iso_year),
    .iso_week        (iso_week),
    .iso_weekday     (iso_weekday)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bit is_leap_year(input int y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic int days_in_year(input int y);
    return is_leap_year(y) ? 366 : 365;
  endfunction

  // weekday code of 31 december, used to tell 53-week years
  function automatic int dec31_weekday_code(input int y);
    return (y + y / 4 - y / 100 + y / 400) % 7;
  endfunction

  function automatic int weeks_of_iso_year(input int y);
    if (dec31_weekday_code(y) == 4 || dec31_weekday_code(y - 1) == 3) return 53;
    return 52;
  endfunction

  function automatic int first_day_of_year(input int y);
    int d;
    d = 0;
    for (int k = 2000; k < y; k++) d += days_in_year(k);
    return d;
  endfunction

  function automatic week_date_t predict_week_date(input logic [15:0] day);
    week_date_t r;
    int         year;
    int         rem;
    int         wday;
    int         week;
    year = 2000;
    rem  = day;
    wday = ((day + 5) % 7) + 1;  // day 2 is a monday
    while (rem >= days_in_year(year)) begin
      rem -= days_in_year(year);
      year++;
    end
    week = (rem + 1 + 10 - wday) / 7;
    if (week < 1) begin
      year--;
      week = weeks_of_iso_year(year);
    end else if (week > weeks_of_iso_year(year)) begin
      year++;
      week = 1;
    end
    r.year = year[11:0];
    r.week = week[5:0];
    r.wday = wday[2:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_day();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      v = $urandom_range(0, 49710);
    end else if (sel < 65) begin
      v = $urandom_range(0, 65535);
    end else begin
      // around new year, where week 1 and week 52/53 swap years
      v = first_day_of_year($urandom_range(2000, 2179)) + $urandom_range(0, 20) - 10;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end
    return v[15:0];
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_day(input logic [15:0] day, input bit known, input week_date_t want);
    int gap;
    bit taken;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid       <= 1'b1;
    days_since_2000 <= day;
    do begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
    end while (!taken);
    expected_dates.push_back(known ? want : predict_week_date(day));
  endtask

  task automatic wait_results_done();
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, checks each transaction against the oldest expectation
  initial begin
    int         n;
    bit         got;
    week_date_t seen;
    week_date_t want;
    rsp_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      n = gaps_on ? $urandom_range(0, 3) : 0;
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do begin
        @(negedge clk);
        got  = rsp_valid;
        seen = '{iso_year, iso_week, iso_weekday};
        @(posedge clk);
      end while (!got);
      if (expected_dates.size() == 0) begin
        report_error($sformatf("unexpected transaction %0d-W%0d-%0d",
                               seen.year, seen.week, seen.wday));
      end else begin
        want = expected_dates.pop_front();
        if (seen.year !== want.year)
          report_error($sformatf("iso_year got %0d want %0d", seen.year, want.year));
        if (seen.week !== want.week)
          report_error($sformatf("iso_week got %0d want %0d", seen.week, want.week));
        if (seen.wday !== want.wday)
          report_error($sformatf("iso_weekday got %0d want %0d", seen.wday, want.wday));
      end
    end
  end

  initial begin
    gaps_on         = 1'b1;
    rst             = 1'b1;
    req_valid       = 1'b0;
    days_since_2000 = '0;

    directed_days = '{
      '{16'd0,     1'b1, 12'd1999, 6'd52, 3'd6},  // 1 jan 2000, saturday
      '{16'd1,     1'b1, 12'd1999, 6'd52, 3'd7},
      '{16'd2,     1'b1, 12'd2000, 6'd1,  3'd1},  // first monday
      '{16'd730,   1'b1, 12'd2002, 6'd1,  3'd1},  // 31 dec 2001 in next year's week 1
      '{16'd1827,  1'b1, 12'd2004, 6'd53, 3'd6},  // 1 jan 2005 in week 53
      '{16'd3,     1'b0, '0, '0, '0},
      '{16'd4,     1'b0, '0, '0, '0},
      '{16'd5,     1'b0, '0, '0, '0},
      '{16'd6,     1'b0, '0, '0, '0},
      '{16'd7,     1'b0, '0, '0, '0},
      '{16'd8,     1'b0, '0, '0, '0},
      '{16'd365,   1'b0, '0, '0, '0},
      '{16'd366,   1'b0, '0, '0, '0},
      '{16'd36525, 1'b0, '0, '0, '0},  // 1 jan 2100
      '{16'd36583, 1'b0, '0, '0, '0},  // 28 feb 2100, no leap day after it
      '{16'd36584, 1'b0, '0, '0, '0},
      '{16'd36889, 1'b0, '0, '0, '0},
      '{16'd36890, 1'b0, '0, '0, '0},
      '{16'd49710, 1'b0, '0, '0, '0},
      '{16'd49711, 1'b0, '0, '0, '0},
      '{16'h5555,  1'b0, '0, '0, '0},
      '{16'hAAAA,  1'b0, '0, '0, '0},
      '{16'h7FFF,  1'b0, '0, '0, '0},
      '{16'h8000,  1'b0, '0, '0, '0},
      '{16'hFFFF,  1'b0, '0, '0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_days[i]) begin
      send_day(directed_days[i].day, directed_days[i].known,
               '{directed_days[i].year, directed_days[i].week, directed_days[i].wday});
    end
    req_valid <= 1'b0;
    wait_results_done();

    // every third block of 100 runs back to back on both sides
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) gaps_on = ((i / 100) % 3) != 2;
      if (i == RANDOM_ITEMS / 2) begin
        req_valid <= 1'b0;
        wait_results_done();
      end
      send_day(pick_day(), 1'b0, '0);
    end
    req_valid <= 1'b0;

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
